// File: hw/rtl/lmqsr_pkg.sv
// shared types and constants for the quarter-scan led matrix refresh block
package lmqsr_pkg;

  localparam int MAX_ROW_BYTES_DEF = 16;
  localparam int PANEL_ROWS        = 16;
  localparam int GROUPS            = 4;
  localparam int ROW_W             = $clog2(PANEL_ROWS);
  localparam int GRP_W             = $clog2(GROUPS);
  localparam int STORE_DEPTH       = 256;
  localparam int STORE_AW          = $clog2(STORE_DEPTH);
  localparam int QUEUE_DEPTH_DEF   = 4;
  localparam int RB_CFG_W          = 5;
  localparam int DUTY_W            = 8;
  localparam int CFG_IDX_W         = 2;

  localparam logic [RB_CFG_W-1:0] ROW_BYTES_RST  = 5'd4;
  localparam logic [DUTY_W-1:0]   BRIGHTNESS_RST = 8'd255;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_SCAN  = 1'b1
  } op_e_t;

  // one queued command: frame store write or scan run
  typedef struct packed {
    op_e_t               op;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          value;
  } cmd_t;

  // queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// File: hw/rtl/lmqsr_front.sv
// front end: takes input transfers, drops skipped scan ticks, feeds the queue
module lmqsr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,
  input  logic [1:0]        s_tuser,
  input  lmqsr_pkg::q_stat_t q_stat,
  output logic              push,
  output lmqsr_pkg::cmd_t   push_cmd
);
  import lmqsr_pkg::*;

  logic  hold_vld;
  cmd_t  hold;
  logic  keep;
  op_e_t in_op;

  assign in_op = op_e_t'(s_tuser[0]);
  // a scan tick that finds the bus busy does nothing at all
  assign keep  = !(in_op == OP_SCAN && s_tuser[1]);

  assign push     = hold_vld && !q_stat.full;
  assign s_tready = !hold_vld || !q_stat.full;
  assign push_cmd = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
    end else if (s_tready) begin
      hold_vld <= s_tvalid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      hold.op    <= in_op;
      hold.addr  <= s_tdata[7:0];
      hold.value <= s_tdata[15:8];
    end
  end

endmodule

// File: hw/rtl/lmqsr_queue.sv
// short command queue between front and back
module lmqsr_queue #(
  parameter int DEPTH = lmqsr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lmqsr_pkg::cmd_t    push_cmd,
  input  logic               pop,
  output lmqsr_pkg::cmd_t    head,
  output lmqsr_pkg::q_stat_t q_stat
);
  import lmqsr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head         = slots[rd_ptr];
  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: hw/rtl/lmqsr_back.sv
// back end: frame store, scan sequencer, read stage and output register
module lmqsr_back #(
  parameter int MAX_ROW_BYTES = lmqsr_pkg::MAX_ROW_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lmqsr_pkg::cmd_t                head,
  input  lmqsr_pkg::q_stat_t             q_stat,
  output logic                           pop,
  input  logic [lmqsr_pkg::RB_CFG_W-1:0] row_bytes,
  input  logic [lmqsr_pkg::DUTY_W-1:0]   brightness,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_last,
  output logic [lmqsr_pkg::GRP_W-1:0]    out_group,
  output logic [lmqsr_pkg::DUTY_W-1:0]   out_duty
);
  import lmqsr_pkg::*;

  localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int RB_W  = $clog2(MAX_ROW_BYTES + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state, state_next;

  logic [7:0]             mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld;

  logic [GRP_W-1:0] scan_group;
  logic [GRP_W-1:0] grp;
  logic [GRP_W-1:0] k;
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] rb_m1;
  logic [RB_W-1:0]  rb;
  logic [RB_W-1:0]  rb_eff;

  logic                issue;
  logic                issue_last;
  logic [ROW_W-1:0]    row;
  logic [STORE_AW-1:0] rd_addr;
  logic                wr_en;
  logic                start;

  logic             s1_valid;
  logic             s1_last;
  logic             s1_hit;
  logic [GRP_W-1:0] s1_grp;
  logic [7:0]       rd_data;
  logic             s1_move;
  logic             s1_free;

  // clamp the configured row length into 1..MAX_ROW_BYTES
  always_comb begin
    if (row_bytes == '0) begin
      rb_eff = RB_W'(1);
    end else if (row_bytes > RB_CFG_W'(MAX_ROW_BYTES)) begin
      rb_eff = RB_W'(MAX_ROW_BYTES);
    end else begin
      rb_eff = RB_W'(row_bytes);
    end
  end

  assign pop   = (state == ST_IDLE) && !q_stat.empty;
  assign wr_en = pop && (head.op == OP_WRITE);
  assign start = pop && (head.op == OP_SCAN);

  // rows go out highest quarter first: group+12, +8, +4, +0
  assign row        = {GRP_W'(GROUPS - 1) - k, grp};
  assign rd_addr    = STORE_AW'(STORE_AW'(row) * STORE_AW'(rb) + STORE_AW'(col));
  assign issue      = (state == ST_SCAN) && s1_free;
  assign issue_last = (col == rb_m1) && (k == GRP_W'(GROUPS - 1));

  assign s1_move = s1_valid && (!out_valid || out_ready);
  assign s1_free = !s1_valid || s1_move;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue && issue_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_group <= '0;
      k          <= '0;
      col        <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        scan_group <= scan_group + 1'b1;
        k          <= '0;
        col        <= '0;
      end else if (issue) begin
        k <= k + 1'b1;
        if (k == GRP_W'(GROUPS - 1)) begin
          col <= col + 1'b1;
        end
      end
    end
  end

  // run parameters captured when the scan starts
  always_ff @(posedge clk) begin
    if (start) begin
      grp   <= scan_group;
      rb    <= rb_eff;
      rb_m1 <= COL_W'(rb_eff - 1'b1);
    end
  end

  // frame store; an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[head.addr] <= head.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[head.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[rd_addr];
      s1_hit  <= vld[rd_addr];
      s1_last <= issue_last;
      s1_grp  <= grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= issue;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_byte  <= s1_hit ? rd_data : 8'd0;
      out_last  <= s1_last;
      out_group <= s1_grp;
      out_duty  <= s1_last ? brightness : '0;
    end
  end

endmodule

// File: hw/rtl/led_matrix_quarter_scan_refresh.sv
// top level of the quarter-scan led matrix refresh engine
//
// s_* channel: one transfer per command. s_tuser[0] selects a frame store
//   write (0) or a scan tick (1); s_tuser[1] marks the shared bus busy, which
//   turns a scan tick into a no-op. writes put s_tdata[15:8] at s_tdata[7:0].
// m_* channel: one transfer per shifted byte. a scan run sends 4 * row_bytes
//   bytes, per column from rows group+12, +8, +4, +0; tlast marks the final
//   byte, which also carries the enable duty; tuser holds the row group.
// cfg_* channel: register writes (row_bytes, brightness), always ready. the
//   user must write only while idle; the block itself does not enforce it.
// throughput: a write is done as it is popped; a scan run holds the back end
//   until its last read is issued, one frame store read a cycle while the
//   output is not stalled. the front register and queue keep taking commands
//   while a run is in progress, until the queue fills.
// when idle and empty, a tick passes the front register, queue, scan state,
//   read stage and output register before its first byte shows on m_tdata.
// reset: clears the queue, pipeline, scan group and the per-entry valid bits,
//   so the whole frame store reads as zero at once; no clearing pass.
// when m_tready is low the output register holds and the read stage and
//   sequencer stall behind it; nothing is dropped.
module led_matrix_quarter_scan_refresh #(
  parameter int MAX_ROW_BYTES = lmqsr_pkg::MAX_ROW_BYTES_DEF,
  parameter int QUEUE_DEPTH   = lmqsr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [15:0]                     s_tdata,   // byte_address, byte_value
  input  logic [1:0]                      s_tuser,   // operation, shared_bus_busy
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,   // shift_byte, enable_duty
  output logic                            m_tlast,
  output logic [lmqsr_pkg::GRP_W-1:0]     m_tuser,   // row_select
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lmqsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);
  import lmqsr_pkg::*;

  logic [RB_CFG_W-1:0] row_bytes;
  logic [DUTY_W-1:0]   brightness;

  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    head;
  logic    push;
  logic    pop;

  logic [7:0]        out_byte;
  logic [DUTY_W-1:0] out_duty;

  // configuration registers; unknown indexes are ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes  <= ROW_BYTES_RST;
      brightness <= BRIGHTNESS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_BYTES:  row_bytes  <= cfg_data[RB_CFG_W-1:0];
        REG_BRIGHTNESS: brightness <= cfg_data;
        default: ;
      endcase
    end
  end

  lmqsr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  lmqsr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  lmqsr_back #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .row_bytes  (row_bytes),
    .brightness (brightness),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (out_byte),
    .out_last   (m_tlast),
    .out_group  (m_tuser),
    .out_duty   (out_duty)
  );

  assign m_tdata = {out_duty, out_byte};

endmodule

// File: hw/rtl/lmqsr_checker.sv
// port-level checks for the refresh engine and their bind
module lmqsr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [15:0]                 m_tdata,
  input logic                        m_tlast,
  input logic [lmqsr_pkg::GRP_W-1:0] m_tuser
);

  // a stalled transfer holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("output changed while stalled");

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // only the final byte of a run carries a duty
  a_duty_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[15:8] == 8'd0)
    else $error("duty on a non-final byte");

  // the row group stays the same through a run
  a_group_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> !m_tvalid || (m_tuser == $past(m_tuser)))
    else $error("row group changed inside a run");

endmodule

bind led_matrix_quarter_scan_refresh lmqsr_checker u_lmqsr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
